>>> src/i2p_pkg.sv
// Shared types and constants of the infix to postfix converter.
`default_nettype none
package i2p_pkg;

  localparam int CODE_WIDTH = 16;
  localparam int STACK_DEPTH = 16;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int PREC_W = 4;

  localparam int INQ_DEPTH = 2;
  localparam int INQ_PTR_W = $clog2(INQ_DEPTH);
  localparam int INQ_CNT_W = $clog2(INQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Input token kinds.
  localparam logic [1:0] KIND_OPERAND = 2'd0;
  localparam logic [1:0] KIND_OPERATOR = 2'd1;
  localparam logic [1:0] KIND_LPAREN = 2'd2;
  localparam logic [1:0] KIND_RPAREN = 2'd3;

  // Result kinds.
  localparam logic [1:0] OUT_OPERAND = 2'd0;
  localparam logic [1:0] OUT_OPERATOR = 2'd1;
  localparam logic [1:0] OUT_END = 2'd2;
  localparam logic [1:0] OUT_ERROR = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCHED = 2'd2;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_OPERATOR,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_FLUSH
  } cmd_t;

  typedef struct packed {
    logic                  op;
    logic [1:0]            token_kind;
    logic [CODE_WIDTH-1:0] token_code;
    logic [PREC_W-1:0]     precedence;
    logic                  right_assoc;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            out_kind;
    logic [CODE_WIDTH-1:0] out_code;
    logic [1:0]            error_code;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [CODE_WIDTH-1:0] code;
    logic [PREC_W-1:0]     prec;
    logic                  rassoc;
  } work_t;

  typedef struct packed {
    logic [CODE_WIDTH-1:0] code;
    logic [PREC_W-1:0]     prec;
    logic                  rassoc;
    logic                  paren;
  } stack_entry_t;

endpackage
`default_nettype wire

>>> src/infix_to_postfix_converter.sv
// Top level of the infix to postfix (shunting-yard) converter.
//
// Usage: tokens enter as requests on a queue-style port; a request is taken
// at a rising edge where push is high and full is low. Results leave through
// a second queue-style port: the oldest result sits on result while empty is
// low and is taken at an edge where pop is high and empty is low. A request
// may produce zero to seventeen results; the final one carries last.
// A request waits in a two-entry front queue, then the engine works on it in
// stack steps: a single step for an operand, a push or an error, plus one
// step per popped stack entry (a flush of n entries takes n + 1 steps).
// Since each operator is pushed and popped once, a stream averages under
// two steps per request. With an idle engine a result passes from the front
// queue through one engine step into the hold register pend and from there
// into the result queue; a result not yet known to be final waits in the
// hold register for the next step.
// A four-entry result queue decouples the engine from the receiver: while
// the receiver stalls the engine keeps working until that queue fills, and
// the front queue keeps taking requests until it too is full.
// Reset (rst, synchronous) empties both queues and the operator stack.
`default_nettype none
module infix_to_postfix_converter
  import i2p_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  // Classified requests flowing from the front end to the engine.
  logic      head_valid;
  work_t     head;
  logic      head_pop;

  // Results flowing from the engine into the result queue.
  logic      outq_full;
  logic      outq_push;
  out_item_t outq_data;

  i2p_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  // Holds the operator stack; one stack step per cycle unless outq is full.
  i2p_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .outq_full  (outq_full),
    .outq_push  (outq_push),
    .outq_data  (outq_data)
  );

  i2p_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (outq_push),
    .wr_data (outq_data),
    .full    (outq_full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

>>> src/i2p_front.sv
// Front end: classifies incoming requests and queues them for the engine.
`default_nettype none
module i2p_front
  import i2p_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output logic          head_valid,
  output work_t         head,
  input  wire logic     head_pop
);

  work_t                mem [INQ_DEPTH];
  logic [INQ_PTR_W-1:0] wr_ptr;
  logic [INQ_PTR_W-1:0] rd_ptr;
  logic [INQ_CNT_W-1:0] count;
  work_t                classified;
  logic                 wr_en;
  logic                 rd_en;

  always_comb begin
    classified.code = item.token_code;
    classified.prec = item.precedence;
    classified.rassoc = item.right_assoc;
    if (item.op) begin
      classified.cmd = CMD_FLUSH;
    end else begin
      unique case (item.token_kind)
        KIND_OPERAND:  classified.cmd = CMD_OPERAND;
        KIND_OPERATOR: classified.cmd = CMD_OPERATOR;
        KIND_LPAREN:   classified.cmd = CMD_LPAREN;
        default:       classified.cmd = CMD_RPAREN;
      endcase
    end
  end

  assign full = (count == INQ_CNT_W'(INQ_DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + INQ_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + INQ_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + INQ_CNT_W'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - INQ_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/i2p_engine.sv
// Back end: operator stack and the step sequencer that emits postfix results.
`default_nettype none
module i2p_engine
  import i2p_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire work_t head,
  output logic       head_pop,
  input  wire logic  outq_full,
  output logic       outq_push,
  output out_item_t  outq_data
);

  stack_entry_t           stack_mem [STACK_DEPTH];
  logic [STACK_CNT_W-1:0] count;
  out_item_t              pend;
  logic                   pend_valid;

  stack_entry_t           top;
  logic                   have;
  logic                   is_full;
  logic                   run;
  logic                   emit;
  logic                   done;
  logic                   do_push;
  logic                   do_pop;
  out_item_t              emit_data;
  logic                   binds;

  assign top = stack_mem[STACK_IDX_W'(count - STACK_CNT_W'(1))];
  assign have = (count != '0);
  assign is_full = (count == STACK_CNT_W'(STACK_DEPTH));
  assign run = head_valid && !outq_full;
  assign binds = (top.prec > head.prec) || ((top.prec == head.prec) && !head.rassoc);

  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    do_push = 1'b0;
    do_pop = 1'b0;
    emit_data = '0;
    unique case (head.cmd)
      CMD_OPERAND: begin
        emit = 1'b1;
        emit_data.out_kind = OUT_OPERAND;
        emit_data.out_code = head.code;
        done = 1'b1;
      end
      CMD_FLUSH: begin
        if (have) begin
          do_pop = 1'b1;
          if (!top.paren) begin
            emit = 1'b1;
            emit_data.out_kind = OUT_OPERATOR;
            emit_data.out_code = top.code;
          end
        end else begin
          emit = 1'b1;
          emit_data.out_kind = OUT_END;
          done = 1'b1;
        end
      end
      CMD_OPERATOR, CMD_LPAREN: begin
        if ((head.cmd == CMD_OPERATOR) && have && !top.paren && binds) begin
          do_pop = 1'b1;
          emit = 1'b1;
          emit_data.out_kind = OUT_OPERATOR;
          emit_data.out_code = top.code;
        end else if (is_full) begin
          emit = 1'b1;
          emit_data.out_kind = OUT_ERROR;
          emit_data.error_code = ERR_OVERFLOW;
          done = 1'b1;
        end else begin
          do_push = 1'b1;
          done = 1'b1;
        end
      end
      CMD_RPAREN: begin
        if (have) begin
          do_pop = 1'b1;
          if (top.paren) begin
            done = 1'b1;
          end else begin
            emit = 1'b1;
            emit_data.out_kind = OUT_OPERATOR;
            emit_data.out_code = top.code;
          end
        end else begin
          emit = 1'b1;
          emit_data.out_kind = OUT_ERROR;
          emit_data.error_code = ERR_UNMATCHED;
          done = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    emit_data.last = done;
  end

  // The newest result waits in pend until the next step shows whether it
  // closes its item; a held result that is already final drains on its own.
  always_comb begin
    outq_push = pend_valid && !outq_full &&
                ((run && (emit || done)) || pend.last);
    outq_data = pend;
    if (run && done && !emit) begin
      outq_data.last = 1'b1;
    end
  end

  assign head_pop = run && done;

  always_ff @(posedge clk) begin
    if (run && emit) begin
      pend <= emit_data;
    end
    if (run && do_push) begin
      stack_mem[STACK_IDX_W'(count)] <= '{code:   head.code,
                                          prec:   head.prec,
                                          rassoc: head.rassoc,
                                          paren:  (head.cmd == CMD_LPAREN)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (run && do_push) begin
        count <= count + STACK_CNT_W'(1);
      end else if (run && do_pop) begin
        count <= count - STACK_CNT_W'(1);
      end
      if (run && emit) begin
        pend_valid <= 1'b1;
      end else if (outq_push) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/i2p_outq.sv
// Result queue between the engine and the result port.
`default_nettype none
module i2p_outq
  import i2p_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_en,
  input  wire out_item_t wr_data,
  output logic           full,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  out_item_t             mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign full = (count == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign empty = (count == '0);
  assign result = mem[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (!do_wr && do_rd) begin
        count <= count - OUTQ_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire
